// File: design/ssort_pkg.sv
// ----------------------------------------------------------------------------
// ssort_pkg: shared definitions for the signed integer sorter
// Sizes of the value store and counters, and the control bundle that the
// sequencer hands to the shared minimum unit.
// ----------------------------------------------------------------------------
package ssort_pkg;

    // store geometry
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // control bundle for the minimum unit
    typedef struct packed {
        logic clear;   // start of a new search pass
        logic valid;   // candidate on the data inputs this cycle
    } min_ctl_t;

endpackage

// File: design/ssort_mem.sv
// ----------------------------------------------------------------------------
// ssort_mem: value store
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module ssort_mem (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ssort_pkg::IDX_W-1:0] wr_addr,
    input  logic [ssort_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ssort_pkg::IDX_W-1:0] rd_addr,
    output logic [ssort_pkg::DATA_W-1:0] rd_data
);

    logic [ssort_pkg::DATA_W-1:0] mem [ssort_pkg::DEPTH];
    logic [ssort_pkg::DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/ssort_min.sv
// ----------------------------------------------------------------------------
// ssort_min: shared signed minimum unit
// One signed comparator and a best-so-far register, fed one candidate per
// cycle during a search pass over the store.
// ----------------------------------------------------------------------------
module ssort_min (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ssort_pkg::min_ctl_t          ctl,
    input  logic [ssort_pkg::DATA_W-1:0] cand_data,
    input  logic [ssort_pkg::IDX_W-1:0]  cand_idx,
    output logic [ssort_pkg::DATA_W-1:0] best_data,
    output logic [ssort_pkg::IDX_W-1:0]  best_idx
);

    logic                         have_reg;
    logic [ssort_pkg::DATA_W-1:0] best_data_reg;
    logic [ssort_pkg::IDX_W-1:0]  best_idx_reg;
    logic                         take;

    // strict less-than keeps the earliest entry on ties
    assign take = ctl.valid && (!have_reg || ($signed(cand_data) < $signed(best_data_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (ctl.clear) begin
            have_reg <= 1'b0;
        end else if (take) begin
            have_reg <= 1'b1;
        end
    end

    // best value and its index
    always_ff @(posedge aclk) begin
        if (!ctl.clear && take) begin
            best_data_reg <= cand_data;
            best_idx_reg  <= cand_idx;
        end
    end

    assign best_data = best_data_reg;
    assign best_idx  = best_idx_reg;

endmodule

// File: design/signed_integer_sorter.sv
// Load: values load at one per cycle. After the last value, each sorted
// result is found by n reads of the store through the one shared comparator,
// followed by the read pipeline register and the output state.
// Throughput: one batch at a time; s_tready is low from the last input
// transfer until the final result transfer.
// Reset: aresetn (synchronous, active low) empties the batch and the output.
// ----------------------------------------------------------------------------
// signed_integer_sorter: batch sorter for 32-bit signed integers
// Collects up to DEPTH values, then emits them in ascending order by
// repeated minimum search over the unused entries of the store.
// ----------------------------------------------------------------------------
module signed_integer_sorter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] overflow
);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [ssort_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                         dropped_reg, dropped_next;
    logic [ssort_pkg::CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [ssort_pkg::IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic                         issue_reg, issue_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [ssort_pkg::IDX_W-1:0]  rd_tag_reg;
    logic [ssort_pkg::DEPTH-1:0]  used_reg, used_next;

    logic                         s_xfer, m_xfer, store_ok, last_out;
    logic [ssort_pkg::CNT_W-1:0]  n_minus1;
    logic [ssort_pkg::DATA_W-1:0] rd_data, best_data;
    logic [ssort_pkg::IDX_W-1:0]  best_idx;
    ssort_pkg::min_ctl_t          min_ctl;

    assign s_tready = (state_reg == S_LOAD);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_EMIT);
    assign m_xfer   = m_tvalid && m_tready;
    assign store_ok = (count_reg < ssort_pkg::CNT_W'(ssort_pkg::DEPTH));
    assign n_minus1 = count_reg - ssort_pkg::CNT_W'(1);
    assign last_out = (out_cnt_reg == n_minus1);

    // value store
    ssort_mem u_mem (
        .aclk    (aclk),
        .wr_en   (s_xfer && store_ok),
        .wr_addr (count_reg[ssort_pkg::IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (issue_reg),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // shared minimum search over entries not yet emitted
    assign min_ctl.clear = (state_reg == S_EMIT) || (state_reg == S_LOAD);
    assign min_ctl.valid = rd_vld_reg && !used_reg[rd_tag_reg];

    ssort_min u_min (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (min_ctl),
        .cand_data (rd_data),
        .cand_idx  (rd_tag_reg),
        .best_data (best_data),
        .best_idx  (best_idx)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        out_cnt_next = out_cnt_reg;
        rd_idx_next  = rd_idx_reg;
        issue_next   = issue_reg;
        rd_vld_next  = 1'b0;
        used_next    = used_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_xfer) begin
                    if (store_ok) begin
                        count_next = count_reg + ssort_pkg::CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next  = S_SCAN;
                        rd_idx_next = '0;
                        issue_next  = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                rd_vld_next = issue_reg;
                if (issue_reg) begin
                    if (ssort_pkg::CNT_W'(rd_idx_reg) == n_minus1) begin
                        issue_next = 1'b0;
                    end else begin
                        rd_idx_next = rd_idx_reg + ssort_pkg::IDX_W'(1);
                    end
                end
                if (rd_vld_reg && (ssort_pkg::CNT_W'(rd_tag_reg) == n_minus1)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_xfer) begin
                    if (last_out) begin
                        state_next   = S_LOAD;
                        count_next   = '0;
                        dropped_next = 1'b0;
                        out_cnt_next = '0;
                        used_next    = '0;
                    end else begin
                        state_next          = S_SCAN;
                        out_cnt_next        = out_cnt_reg + ssort_pkg::CNT_W'(1);
                        used_next[best_idx] = 1'b1;
                        rd_idx_next         = '0;
                        issue_next          = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            out_cnt_reg <= '0;
            rd_idx_reg  <= '0;
            issue_reg   <= 1'b0;
            rd_vld_reg  <= 1'b0;
            used_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            out_cnt_reg <= out_cnt_next;
            rd_idx_reg  <= rd_idx_next;
            issue_reg   <= issue_next;
            rd_vld_reg  <= rd_vld_next;
            used_reg    <= used_next;
        end
    end

    // read tag follows the read data
    always_ff @(posedge aclk) begin
        rd_tag_reg <= rd_idx_reg;
    end

    // result channel
    assign m_tdata    = best_data;
    assign m_tlast    = last_out;
    assign m_tuser[0] = dropped_reg;

endmodule

// File: design/ssort_checker.sv
// ----------------------------------------------------------------------------
// ssort_checker: port-level checks for the signed integer sorter
// Watches both channels and checks ordering and batch sequencing.
// ----------------------------------------------------------------------------
module ssort_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    logic [31:0] prev_reg;
    logic        prev_vld_reg;

    // last result value of the current batch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_vld_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            prev_vld_reg <= !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            prev_reg <= m_tdata;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // input and output never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is shown");

    // results of a batch come out ascending
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && prev_vld_reg |-> $signed(prev_reg) <= $signed(m_tdata))
        else $error("results out of order");

    // the final result reopens the input
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("input not reopened after batch");

    // a marked input closes the input
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after last transfer");

endmodule

bind signed_integer_sorter ssort_checker u_ssort_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: test/signed_integer_sorter_tb.sv
// ----------------------------------------------------------------------------
// signed_integer_sorter_tb: self-checking bench for the signed batch sorter
// Streams lists of signed 32-bit values into the sorter and predicts each
// sorted batch, including the overflow flag when the store runs out of
// room. Every output transfer is compared field by field with the oldest
// prediction. Both sides idle at random, with back-pressure and drain phases.
// ----------------------------------------------------------------------------
module signed_integer_sorter_tb;

    localparam int DEPTH  = ssort_pkg::DEPTH;
    localparam int DATA_W = ssort_pkg::DATA_W;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int MAX_REPORTS = 20;

    // one output transfer as the sorter should produce it
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     final_res;
        logic                     overflow;
    } sorted_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    // predictor state: values held for the current batch
    logic signed [DATA_W-1:0] held_values [DEPTH];
    int                       held_count;
    logic                     held_dropped;
    sorted_result_t           sorted_out_q [$];

    int mismatches;
    int hold_request;
    int hold_left;
    bit no_idle;

    signed_integer_sorter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock, period 2
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // Insertion sort gives plain ascending signed order;
    // equal values are indistinguishable on the output.
    task automatic sort_held_values();
        logic signed [DATA_W-1:0] v;
        int j;
        for (int i = 1; i < held_count; i++) begin
            v = held_values[i];
            j = i;
            while (j > 0 && held_values[j-1] > v) begin
                held_values[j] = held_values[j-1];
                j--;
            end
            held_values[j] = v;
        end
    endtask

    // account for one accepted input transfer
    task automatic take_value(input logic signed [DATA_W-1:0] v, input logic lst);
        sorted_result_t r;
        if (held_count < DEPTH) begin
            held_values[held_count] = v;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (lst) begin
            sort_held_values();
            for (int k = 0; k < held_count; k++) begin
                r.value     = held_values[k];
                r.final_res = (k == held_count - 1);
                r.overflow  = held_dropped;
                sorted_out_q.push_back(r);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint exp_v,
                                   input longint got_v);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v,
                     got_v);
        mismatches++;
    endtask

    // compare every output transfer with the oldest prediction
    always @(posedge aclk) begin
        sorted_result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (sorted_out_q.size() == 0) begin
                report_mismatch("unexpected result, sorted_value", 0,
                                $signed(m_tdata));
            end else begin
                r = sorted_out_q.pop_front();
                if (m_tdata !== r.value)
                    report_mismatch("sorted_value", r.value, $signed(m_tdata));
                if (m_tlast !== r.final_res)
                    report_mismatch("final_res", r.final_res, m_tlast);
                if (m_tuser[0] !== r.overflow)
                    report_mismatch("overflow", r.overflow, m_tuser[0]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // output side: random idling plus requested long holds
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 20);
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // one input transfer, with random idle cycles before it
    task automatic send_value(input logic signed [DATA_W-1:0] v, input logic lst);
        while (!no_idle && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        take_value(v, lst);
    endtask

    // drop valid after the last transfer of a phase
    task automatic stop_sending();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (sorted_out_q.size() != 0) @(posedge aclk);
    endtask

    // mostly full-range values, with extremes and a cluster of small ones for ties
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_batch(input int n);
        for (int i = 0; i < n; i++)
            send_value(pick_value(), i == n - 1);
    endtask

    task automatic send_list(input logic signed [DATA_W-1:0] vals [$]);
        foreach (vals[i])
            send_value(vals[i], i == vals.size() - 1);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // one-value batches at both extremes and zero
    task automatic test_single_values();
        send_value(VAL_MIN, 1'b1);
        send_value(VAL_MAX, 1'b1);
        send_value(0, 1'b1);
        stop_sending();
    endtask

    // extremes mixed, near-extremes that would overflow a subtracting compare
    task automatic test_extremes();
        send_list('{VAL_MAX, VAL_MIN, 0, -1, 1, 32'sh8000_0001, 32'sh7FFF_FFFE,
                    VAL_MIN});
        stop_sending();
    endtask

    // all equal values
    task automatic test_duplicates();
        send_list('{-7, -7, -7, -7});
        stop_sending();
    endtask

    // descending input, odd length
    task automatic test_descending();
        send_list('{1000, 500, 3, 0, -3, -500, -1000});
        stop_sending();
    endtask

    // exactly full store, one past full (dropped last), and several past full
    task automatic test_store_full();
        send_batch(DEPTH);
        send_batch(DEPTH + 1);
        send_batch(DEPTH + 6);
        stop_sending();
    endtask

    // receiver stalls long enough for the input to back up behind a batch
    task automatic test_receiver_hold();
        hold_request = 400;
        send_batch(10);
        send_batch(6);
        stop_sending();
    endtask

    // sender waits for every result before the next batch
    task automatic test_sender_pause();
        send_batch(5);
        stop_sending();
        wait_drained();
        send_batch(3);
        stop_sending();
    endtask

    // random batch sizes, mostly small, with a stretch of no idling
    task automatic test_random_batches();
        int sent;
        int n;
        sent = 0;
        while (sent < 125) begin
            no_idle = (sent >= 50 && sent < 90);
            n = ($urandom_range(19) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            send_batch(n);
            sent += n;
        end
        no_idle = 1'b0;
        stop_sending();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tlast      <= 1'b0;
        m_tready     <= 1'b0;
        held_count   = 0;
        held_dropped = 1'b0;
        mismatches   = 0;
        hold_request = 0;
        hold_left    = 0;
        no_idle      = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_values();
        test_extremes();
        test_duplicates();
        test_descending();
        test_store_full();
        test_receiver_hold();
        test_sender_pause();
        test_random_batches();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("signed_integer_sorter_tb: PASS");
        end else begin
            $display("signed_integer_sorter_tb: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("signed_integer_sorter_tb: FAIL");
        $finish;
    end

endmodule
